/* rtl/core/qxmms_pkg.sv */
// ----------------------------------------------------------------------------
// qxmms_pkg: shared types and constants of the quad X motor mixer
// Field widths, register reset values, register indexes and word layouts.
// ----------------------------------------------------------------------------
package qxmms_pkg;

   localparam int unsigned PULSE_W    = 12;
   localparam int unsigned CORR_W     = 12;
   localparam int unsigned STEP_W     = 8;
   localparam int unsigned CMP_W      = 16;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 12;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 104;

   localparam int unsigned CMP_SCALE_DEF = 16;

   localparam logic [STEP_W-1:0]  SLEW_STEP_RST    = 8'd20;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RST    = 12'd1000;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RST    = 12'd2000;
   localparam logic [PULSE_W-1:0] ARM_THROTTLE_RST = 12'd1250;
   localparam logic [PULSE_W-1:0] IDLE_PULSE       = 12'd1000;
   localparam logic [PULSE_W-1:0] WIDTH_MAX        = 12'd4095;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SLEW_STEP    = 2'd0,
      CSR_PULSE_MIN    = 2'd1,
      CSR_PULSE_MAX    = 2'd2,
      CSR_ARM_THROTTLE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                      armed;
      logic signed [CORR_W-1:0]  extra_corr;
      logic signed [CORR_W-1:0]  yaw_cmd;
      logic signed [CORR_W-1:0]  pitch_cmd;
      logic signed [CORR_W-1:0]  roll_cmd;
      logic        [PULSE_W-1:0] throttle;
   } tick_type;

endpackage

/* rtl/core/quad_x_motor_mixer_slew_core.sv */
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_slew_core: X-frame motor mixer with slewed corrections
// Slew-limits roll, pitch and yaw; if armed above arm throttle, mixes four motors,
// clamps, adds extra correction, saturates, scales each width to a timer compare.
// ----------------------------------------------------------------------------
// channel | direction | payload (lowest bit first)
// req_    | in        | tdata: throttle, roll_cmd, pitch_cmd, yaw_cmd, extra_corr;
//         |           | tuser: armed
// rsp_    | out       | tdata: motor1..4_cmp, roll/pitch/yaw_smooth
// csr_    | in        | we, addr (register index), wdata
// One word per cycle when results are taken; input register feeds result register.
// The slew state is read and updated in the compute step, when a word advances.
// Reset clears the valid flags and slew state and loads the register reset values.
// A stalled result holds; the input register still drains into it when free.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_slew_core #(
   parameter int unsigned CMP_SCALE = qxmms_pkg::CMP_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // throttle[11:0], roll_cmd[23:12], pitch_cmd[35:24], yaw_cmd[47:36],
   // extra_corr[59:48], zero[63:60]
   input  logic [qxmms_pkg::REQ_DATA_W-1:0]    req_tdata,
   // armed[0]
   input  logic [qxmms_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // motor1_cmp[15:0], motor2_cmp[31:16], motor3_cmp[47:32], motor4_cmp[63:48],
   // roll_smooth[75:64], pitch_smooth[87:76], yaw_smooth[99:88], zero[103:100]
   output logic [qxmms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [qxmms_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [qxmms_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned PW   = qxmms_pkg::PULSE_W;
   localparam int unsigned CW   = qxmms_pkg::CORR_W;
   localparam int unsigned SW   = qxmms_pkg::STEP_W;
   localparam int unsigned MW   = qxmms_pkg::CMP_W;
   localparam int unsigned MIXW = 15;
   localparam int unsigned PRDW = MW + 1;

   logic [SW-1:0] slew_step_ff;
   logic [PW-1:0] pulse_min_ff;
   logic [PW-1:0] pulse_max_ff;
   logic [PW-1:0] arm_throttle_ff;

   logic                 in_valid_ff;
   qxmms_pkg::tick_type  in_tick_ff;
   logic signed [CW-1:0] prev_roll_ff, prev_pitch_ff, prev_yaw_ff;
   logic                 out_valid_ff;
   logic [qxmms_pkg::RSP_DATA_W-1:0] out_data_ff;

   logic                 advance;
   logic signed [CW-1:0] roll_in, pitch_in, yaw_in;
   logic                 mixing;
   logic signed [MIXW-1:0] t_s, r_s, p_s, y_s;
   logic [MW-1:0]        m1_in, m2_in, m3_in, m4_in;
   logic [qxmms_pkg::RSP_DATA_W-1:0] out_data_in;

   function automatic logic signed [CW-1:0] slew_f(
      input logic signed [CW-1:0] prev,
      input logic signed [CW-1:0] cmd,
      input logic [SW-1:0]        step
   );
      logic signed [CW:0] diff;
      logic signed [CW:0] s;
      logic signed [CW:0] res;
      diff = CW'(0) + ($signed({cmd[CW-1], cmd}) - $signed({prev[CW-1], prev}));
      s    = $signed({{(CW+1-SW){1'b0}}, step});
      if (diff < -s) begin
         res = $signed({prev[CW-1], prev}) - s;
      end else if (diff > s) begin
         res = $signed({prev[CW-1], prev}) + s;
      end else begin
         res = $signed({cmd[CW-1], cmd});
      end
      return res[CW-1:0];
   endfunction

   function automatic logic [MW-1:0] motor_f(
      input logic signed [MIXW-1:0] mix,
      input logic signed [CW-1:0]   extra,
      input logic [PW-1:0]          lo,
      input logic [PW-1:0]          hi
   );
      logic signed [MIXW-1:0] lo_s;
      logic signed [MIXW-1:0] hi_s;
      logic signed [MIXW-1:0] clamped;
      logic signed [MIXW-1:0] w;
      logic [PW-1:0]          w_sat;
      logic [PRDW-1:0]        prod;
      lo_s = $signed({{(MIXW-PW){1'b0}}, lo});
      hi_s = $signed({{(MIXW-PW){1'b0}}, hi});
      if (mix < lo_s) begin
         clamped = lo_s;
      end else if (mix > hi_s) begin
         clamped = hi_s;
      end else begin
         clamped = mix;
      end
      w = clamped + $signed({{(MIXW-CW){extra[CW-1]}}, extra});
      if (w < 0) begin
         w_sat = '0;
      end else if (w > $signed({{(MIXW-PW){1'b0}}, qxmms_pkg::WIDTH_MAX})) begin
         w_sat = qxmms_pkg::WIDTH_MAX;
      end else begin
         w_sat = w[PW-1:0];
      end
      prod = PRDW'(w_sat) * PRDW'(CMP_SCALE);
      return prod[MW-1:0];
   endfunction

   // input word held and result register free or drained this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      logic [PRDW-1:0] idle_prod;
      roll_in  = slew_f(prev_roll_ff,  in_tick_ff.roll_cmd,  slew_step_ff);
      pitch_in = slew_f(prev_pitch_ff, in_tick_ff.pitch_cmd, slew_step_ff);
      yaw_in   = slew_f(prev_yaw_ff,   in_tick_ff.yaw_cmd,   slew_step_ff);
      mixing   = in_tick_ff.armed && (in_tick_ff.throttle > arm_throttle_ff);
      t_s = $signed({{(MIXW-PW){1'b0}}, in_tick_ff.throttle});
      r_s = $signed({{(MIXW-CW){roll_in[CW-1]}}, roll_in});
      p_s = $signed({{(MIXW-CW){pitch_in[CW-1]}}, pitch_in});
      y_s = $signed({{(MIXW-CW){yaw_in[CW-1]}}, yaw_in});
      idle_prod = PRDW'(qxmms_pkg::IDLE_PULSE) * PRDW'(CMP_SCALE);
      if (mixing) begin
         m1_in = motor_f(t_s - r_s - p_s + y_s, in_tick_ff.extra_corr,
                         pulse_min_ff, pulse_max_ff);
         m2_in = motor_f(t_s + r_s - p_s - y_s, in_tick_ff.extra_corr,
                         pulse_min_ff, pulse_max_ff);
         m3_in = motor_f(t_s + r_s + p_s + y_s, in_tick_ff.extra_corr,
                         pulse_min_ff, pulse_max_ff);
         m4_in = motor_f(t_s - r_s + p_s - y_s, in_tick_ff.extra_corr,
                         pulse_min_ff, pulse_max_ff);
      end else begin
         m1_in = idle_prod[MW-1:0];
         m2_in = idle_prod[MW-1:0];
         m3_in = idle_prod[MW-1:0];
         m4_in = idle_prod[MW-1:0];
      end
      out_data_in = {4'b0000, yaw_in, pitch_in, roll_in, m4_in, m3_in, m2_in, m1_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_step_ff    <= qxmms_pkg::SLEW_STEP_RST;
         pulse_min_ff    <= qxmms_pkg::PULSE_MIN_RST;
         pulse_max_ff    <= qxmms_pkg::PULSE_MAX_RST;
         arm_throttle_ff <= qxmms_pkg::ARM_THROTTLE_RST;
      end else if (csr_we) begin
         unique case (qxmms_pkg::csr_index_type'(csr_addr))
            qxmms_pkg::CSR_SLEW_STEP:    slew_step_ff    <= csr_wdata[SW-1:0];
            qxmms_pkg::CSR_PULSE_MIN:    pulse_min_ff    <= csr_wdata[PW-1:0];
            qxmms_pkg::CSR_PULSE_MAX:    pulse_max_ff    <= csr_wdata[PW-1:0];
            qxmms_pkg::CSR_ARM_THROTTLE: arm_throttle_ff <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_roll_ff  <= '0;
         prev_pitch_ff <= '0;
         prev_yaw_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            prev_roll_ff  <= roll_in;
            prev_pitch_ff <= pitch_in;
            prev_yaw_ff   <= yaw_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tick_ff.throttle   <= req_tdata[11:0];
         in_tick_ff.roll_cmd   <= req_tdata[23:12];
         in_tick_ff.pitch_cmd  <= req_tdata[35:24];
         in_tick_ff.yaw_cmd    <= req_tdata[47:36];
         in_tick_ff.extra_corr <= req_tdata[59:48];
         in_tick_ff.armed      <= req_tuser[0];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* rtl/core/qxmms_checker.sv */
// ----------------------------------------------------------------------------
// qxmms_checker: port-level checks of the quad X motor mixer
// Watches reset behavior, result hold under stall and input readiness.
// ----------------------------------------------------------------------------
module qxmms_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [qxmms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // drop any result on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // hold a stalled result word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   // an empty result side never blocks input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty result register");

   // an accepted word reaches the result side when accepted with the result side empty
   a_word_arrives: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> ##1 rsp_tvalid)
      else $error("accepted word did not reach result register");

   // keep padding bits clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[103:100] == 4'b0000))
      else $error("result padding bits set");

endmodule

bind quad_x_motor_mixer_slew_core qxmms_checker u_qxmms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/mixer_checker.sv */
// ----------------------------------------------------------------------------
// mixer_checker: result predictor and comparator for the quad X motor mixer
// Watches the request, result and register channels. Keeps its own copy of
// the slew state and registers, predicts the motor compares and smoothed
// corrections for every accepted tick, and compares each accepted result
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mixer_checker #(
   parameter int unsigned CMP_SCALE = qxmms_pkg::CMP_SCALE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [qxmms_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [qxmms_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [qxmms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [qxmms_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [qxmms_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatches,
   output int                               pending,
   output int                               ticks_checked
);
   import qxmms_pkg::*;

   typedef struct packed {
      logic [3:0]                 pad;
      logic signed [CORR_W-1:0]   yaw_smooth;
      logic signed [CORR_W-1:0]   pitch_smooth;
      logic signed [CORR_W-1:0]   roll_smooth;
      logic [3:0][CMP_W-1:0]      motor_cmp;
   } mix_out_type;

   logic [STEP_W-1:0]         step_cfg;
   logic [PULSE_W-1:0]        window_lo;
   logic [PULSE_W-1:0]        window_hi;
   logic [PULSE_W-1:0]        arm_level;
   logic signed [CORR_W-1:0]  kept_roll;
   logic signed [CORR_W-1:0]  kept_pitch;
   logic signed [CORR_W-1:0]  kept_yaw;

   mix_out_type expected_mix[$];
   mix_out_type got_mix;
   mix_out_type want_mix;

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("checker: %s", msg);
   endtask

   function automatic logic signed [CORR_W-1:0] slew_toward(
      input logic signed [CORR_W-1:0] prev, input logic signed [CORR_W-1:0] cmd);
      int s;
      int d;
      s = int'(step_cfg);
      d = int'(cmd) - int'(prev);
      if (d < -s) d = -s;
      else if (d > s) d = s;
      return CORR_W'(int'(prev) + d);
   endfunction

   function automatic logic [CMP_W-1:0] motor_cmp(input int mix, input int extra);
      int w;
      w = mix;
      if (w < int'(window_lo)) w = int'(window_lo);
      else if (w > int'(window_hi)) w = int'(window_hi);
      w = w + extra;
      if (w < 0) w = 0;
      else if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
      return CMP_W'(w * int'(CMP_SCALE));
   endfunction

   function automatic mix_out_type mix_tick(input tick_type t);
      mix_out_type o;
      int th;
      int r;
      int p;
      int y;
      int ex;
      o = '0;
      kept_roll  = slew_toward(kept_roll, t.roll_cmd);
      kept_pitch = slew_toward(kept_pitch, t.pitch_cmd);
      kept_yaw   = slew_toward(kept_yaw, t.yaw_cmd);
      th = int'(t.throttle);
      r  = int'(kept_roll);
      p  = int'(kept_pitch);
      y  = int'(kept_yaw);
      ex = int'(t.extra_corr);
      if (t.armed && (t.throttle > arm_level)) begin
         o.motor_cmp[0] = motor_cmp(th - r - p + y, ex);
         o.motor_cmp[1] = motor_cmp(th + r - p - y, ex);
         o.motor_cmp[2] = motor_cmp(th + r + p + y, ex);
         o.motor_cmp[3] = motor_cmp(th - r + p - y, ex);
      end else begin
         for (int m = 0; m < 4; m++) o.motor_cmp[m] = CMP_W'(int'(IDLE_PULSE) * int'(CMP_SCALE));
      end
      o.roll_smooth  = kept_roll;
      o.pitch_smooth = kept_pitch;
      o.yaw_smooth   = kept_yaw;
      return o;
   endfunction

   task automatic compare_mix(input mix_out_type got, input mix_out_type want);
      for (int m = 0; m < 4; m++) begin
         if (got.motor_cmp[m] !== want.motor_cmp[m])
            report($sformatf("result %0d motor%0d_cmp got %0d want %0d", ticks_checked,
                             m + 1, got.motor_cmp[m], want.motor_cmp[m]));
      end
      if (got.roll_smooth !== want.roll_smooth)
         report($sformatf("result %0d roll_smooth got %0d want %0d", ticks_checked,
                          got.roll_smooth, want.roll_smooth));
      if (got.pitch_smooth !== want.pitch_smooth)
         report($sformatf("result %0d pitch_smooth got %0d want %0d", ticks_checked,
                          got.pitch_smooth, want.pitch_smooth));
      if (got.yaw_smooth !== want.yaw_smooth)
         report($sformatf("result %0d yaw_smooth got %0d want %0d", ticks_checked,
                          got.yaw_smooth, want.yaw_smooth));
      if (got.pad !== want.pad)
         report($sformatf("result %0d pad bits got %0h want 0", ticks_checked, got.pad));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_cfg   = SLEW_STEP_RST;
         window_lo  = PULSE_MIN_RST;
         window_hi  = PULSE_MAX_RST;
         arm_level  = ARM_THROTTLE_RST;
         kept_roll  = '0;
         kept_pitch = '0;
         kept_yaw   = '0;
         expected_mix.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_SLEW_STEP:    step_cfg  = csr_wdata[STEP_W-1:0];
               CSR_PULSE_MIN:    window_lo = csr_wdata[PULSE_W-1:0];
               CSR_PULSE_MAX:    window_hi = csr_wdata[PULSE_W-1:0];
               CSR_ARM_THROTTLE: arm_level = csr_wdata[PULSE_W-1:0];
               default: ;
            endcase
         end
         // pop before push: a word accepted now never belongs to a tick taken now
         if (rsp_tvalid && rsp_tready) begin
            got_mix = mix_out_type'(rsp_tdata);
            if (expected_mix.size() == 0) begin
               report($sformatf("result word with no tick pending: %h", rsp_tdata));
            end else begin
               want_mix = expected_mix.pop_front();
               compare_mix(got_mix, want_mix);
            end
            ticks_checked++;
         end
         if (req_tvalid && req_tready)
            expected_mix.push_back(mix_tick(tick_type'({req_tuser[0], req_tdata[59:0]})));
      end
      pending <= expected_mix.size();
   end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the quad X motor mixer
// Drives directed corner ticks, then random ticks held on slowly changing
// targets across several register settings, with bursty input, a patterned
// output stall and long output hold-offs. The checker beside the block does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
   import qxmms_pkg::*;

   localparam int HOLD_LEN       = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE         = 6;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_SPARSE
   } sink_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int pending;
   int ticks_checked;
   int ticks_sent;
   int settings_applied;
   int idle_cycles;
   int hold_asks;
   int holds_done;
   int hold_cycles;
   int mode_left;
   int burst_left;
   int aim_left;
   sink_mode_type sink_mode = READY_ALWAYS;

   logic [PULSE_W-1:0]       cur_arm = ARM_THROTTLE_RST;
   logic signed [CORR_W-1:0] aim_roll;
   logic signed [CORR_W-1:0] aim_pitch;
   logic signed [CORR_W-1:0] aim_yaw;

   quad_x_motor_mixer_slew_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mixer_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending       (pending),
      .ticks_checked (ticks_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (holds_done < hold_asks) begin
         rsp_tready <= 1'b0;
         if (hold_cycles == HOLD_LEN - 1) begin
            hold_cycles <= 0;
            holds_done  <= holds_done + 1;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end else begin
         if (mode_left == 0) begin
            sink_mode <= sink_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (sink_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic push_tick(input tick_type t);
      req_tdata  <= {4'b0, t.extra_corr, t.yaw_cmd, t.pitch_cmd, t.roll_cmd, t.throttle};
      req_tuser  <= t.armed;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic send(input int th, input int r, input int p, input int y,
                       input bit armed, input int ex);
      tick_type t;
      t.throttle   = PULSE_W'(th);
      t.roll_cmd   = CORR_W'(r);
      t.pitch_cmd  = CORR_W'(p);
      t.yaw_cmd    = CORR_W'(y);
      t.armed      = armed;
      t.extra_corr = CORR_W'(ex);
      push_tick(t);
   endtask

   // hold valid through a burst, drop it for a random gap between bursts
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] slew_raw,
                                 input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                                 input logic [PULSE_W-1:0] arm);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SLEW_STEP;
      csr_wdata <= slew_raw;
      @(posedge clock);
      csr_addr  <= CSR_PULSE_MIN;
      csr_wdata <= lo;
      @(posedge clock);
      csr_addr  <= CSR_PULSE_MAX;
      csr_wdata <= hi;
      @(posedge clock);
      csr_addr  <= CSR_ARM_THROTTLE;
      csr_wdata <= arm;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_arm = arm;
      settings_applied++;
   endtask

   function automatic logic signed [CORR_W-1:0] pick_aim();
      case ($urandom_range(0, 3))
         0:       return 12'sd2047;
         1:       return -12'sd2048;
         default: return CORR_W'($urandom);
      endcase
   endfunction

   // mostly armed ticks at or above threshold that chase a held target, some noise
   task automatic next_tick(output tick_type t);
      if (aim_left == 0) begin
         aim_roll  = pick_aim();
         aim_pitch = pick_aim();
         aim_yaw   = pick_aim();
         aim_left  = $urandom_range(1, 14);
      end
      aim_left--;
      if ($urandom_range(0, 9) < 7) begin
         t.armed     = 1'b1;
         t.roll_cmd  = aim_roll;
         t.pitch_cmd = aim_pitch;
         t.yaw_cmd   = aim_yaw;
         if ($urandom_range(0, 9) == 0 || cur_arm == WIDTH_MAX)
            t.throttle = cur_arm + PULSE_W'($urandom_range(0, 1));
         else
            t.throttle = PULSE_W'($urandom_range(int'(cur_arm) + 1, 4095));
         if ($urandom_range(0, 3) == 0)
            t.extra_corr = CORR_W'($urandom);
         else
            t.extra_corr = CORR_W'(int'($urandom_range(0, 400)) - 200);
      end else begin
         t = tick_type'({$urandom, $urandom});
      end
   endtask

   task automatic run_random(input int n, input int hold_at);
      tick_type t;
      for (int i = 0; i < n; i++) begin
         if (i == hold_at) hold_asks <= hold_asks + 1;
         next_tick(t);
         push_tick(t);
         pace();
      end
   endtask

   initial begin
      logic [PULSE_W-1:0] lo;
      logic [PULSE_W-1:0] hi;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: idle paths, threshold edge, clamp
      send(0, 0, 0, 0, 1'b0, 0);
      send(4095, 2047, -2048, 2047, 1'b0, 2047);
      send(1250, 100, 100, 100, 1'b1, 0);
      send(1251, 100, -100, 50, 1'b1, 0);
      send(1500, 0, 0, 0, 1'b1, 0);
      send(1500, -2048, 2047, -2048, 1'b1, -2048);
      send(4095, 0, 0, 0, 1'b1, 2047);
      send(0, -1, -1, -1, 1'b1, -1);
      drain();

      // full window, fast slew: drive widths into both saturation limits
      apply_settings(12'd255, 12'd0, 12'd4095, 12'd0);
      repeat (8) send(4095, 2047, 2047, 2047, 1'b1, 2047);
      repeat (5) send(4095, -2048, -2048, -2048, 1'b1, -2048);
      send(1, 0, 0, 0, 1'b1, 0);
      send(0, 0, 0, 0, 1'b1, 0);
      drain();

      apply_settings(12'd255, 12'd1000, 12'd2000, 12'd1250);
      run_random(70, 20);
      drain();
      apply_settings(12'd0, 12'd1000, 12'd2000, 12'd1250);
      run_random(30, -1);
      drain();
      // upper slew bits are not part of the register
      apply_settings(12'hF40, 12'd3000, 12'd500, 12'd1000);
      run_random(60, -1);
      drain();
      apply_settings(12'd255, 12'd0, 12'd4095, 12'd0);
      run_random(60, -1);
      drain();
      apply_settings(12'd1, 12'd4095, 12'd4095, 12'd4095);
      run_random(25, -1);
      drain();
      for (int k = 0; k < 5; k++) begin
         lo = PULSE_W'($urandom_range(0, 2000));
         hi = PULSE_W'($urandom_range(1500, 4095));
         if ($urandom_range(0, 3) == 0)
            apply_settings(CSR_DATA_W'($urandom), hi, lo, PULSE_W'($urandom_range(0, 2500)));
         else
            apply_settings(CSR_DATA_W'($urandom), lo, hi, PULSE_W'($urandom_range(0, 2500)));
         run_random(40, (k == 0) ? 15 : -1);
         drain();
      end

      $display("covered %0d ticks, %0d results checked, %0d register settings",
               ticks_sent, ticks_checked, settings_applied);
      $display("normal, inverted and full windows, zero and full slew, %0d long output stalls",
               holds_done);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/qxmms_pkg.sv
rtl/core/quad_x_motor_mixer_slew_core.sv
rtl/core/qxmms_checker.sv
tb/sv/mixer_checker.sv
tb/sv/testbench.sv
